// File: rtl/pes_pkg.sv
// Package for the pose error statistics block: shared widths, request codes and the
// control types of the iterative divide / square-root unit.
// No dependencies.
package pes_pkg;

    // Default sizing of the per-target statistics.
    localparam int PES_COUNT_BITS  = 20;
    localparam int PES_NUM_TARGETS = 2;

    // Request kinds carried in the input tuser.
    localparam logic [1:0] REQ_TRUTH    = 2'd0;
    localparam logic [1:0] REQ_ESTIMATE = 2'd1;
    localparam logic [1:0] REQ_REPORT   = 2'd2;

    // Operand register of the iterative unit and the width of a square root of it.
    localparam int OPND_W = 56;
    localparam int ROOT_W = OPND_W / 2;
    localparam int STEP_W = 6;

    // Step counts of the three jobs the unit runs.
    localparam logic [STEP_W-1:0] SQRT_STEPS    = STEP_W'(ROOT_W);
    localparam int                SUM_W         = 38;
    localparam int                SQS_W         = 55;
    localparam logic [STEP_W-1:0] SUM_DIV_STEPS = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] SQS_DIV_STEPS = STEP_W'(SQS_W);

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_iter_op;

    typedef struct packed {
        logic              start;
        t_iter_op          op;
        logic [STEP_W-1:0] steps;
    } t_iter_ctrl;

endpackage

// File: rtl/pes_iter_unit.sv
// Shared iterative unit: restoring division and digit-by-digit square root, one
// result bit per cycle through a single subtract-and-compare. Depends on pes_pkg.
module pes_iter_unit
    import pes_pkg::*;
#(
    parameter int COUNT_BITS = PES_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_iter_ctrl            i_ctrl,
    input  logic [OPND_W-1:0]     i_operand,
    input  logic [COUNT_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [OPND_W-1:0]     o_quot,
    output logic [ROOT_W-1:0]     o_root
);

    // The remainder must hold a shifted divisor-sized value or a shifted root remainder.
    localparam int SQRT_REM_W = ROOT_W + 4;
    localparam int SUB_W = (COUNT_BITS + 1 > SQRT_REM_W) ? COUNT_BITS + 1 : SQRT_REM_W;

    t_iter_op              r_op;
    logic [OPND_W-1:0]     r_opnd;
    logic [SUB_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [COUNT_BITS-1:0] r_div;
    logic [STEP_W-1:0]     r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [SUB_W-1:0] a_sh;
    logic [SUB_W-1:0] b_op;
    logic [SUB_W:0]   diff;
    logic             take;

    // Bring in the next operand bits and form the trial subtrahend.
    always_comb begin
        if (r_op == OP_SQRT) begin
            a_sh = {r_rem[SUB_W-3:0], r_opnd[OPND_W-1 -: 2]};
            b_op = SUB_W'({r_root, 2'b01});
        end else begin
            a_sh = {r_rem[SUB_W-2:0], r_opnd[OPND_W-1]};
            b_op = SUB_W'(r_div);
        end
        diff = {1'b0, a_sh} - {1'b0, b_op};
        take = ~diff[SUB_W];
    end

    // Sequencing of the steps; the result bit is shifted in on every step.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_ctrl.start) begin
            r_op   <= i_ctrl.op;
            r_opnd <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
            r_div  <= i_divisor;
            r_cnt  <= i_ctrl.steps;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= take ? diff[SUB_W-1:0] : a_sh;
            if (r_op == OP_SQRT) begin
                r_opnd <= {r_opnd[OPND_W-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], take};
            end else begin
                r_opnd <= {r_opnd[OPND_W-2:0], take};
            end
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_opnd;
    assign o_root = r_root;

endmodule

// File: rtl/pose_error_statistics_top.sv
// Pose error statistics: scores position estimates against a stored truth point and
// keeps per-target running count, sum and sum of squares. Depends on pes_pkg, pes_iter_unit.
//
// The block takes one item at a time. A truth update, an unused request or a report on a
// target without samples bypasses the shared divide / square-root unit; an estimate runs
// one square root on it and a report two divisions and a square root. The unit produces
// one result bit per cycle. A finished result waits in an output register, so the next
// item is taken while it is still pending; if that register still holds an untaken result
// when the next one is finished, the block stays busy until the result side takes it.
// Every item yields exactly one result item. The gate limit is written through the
// configuration channel, which is always ready.
module pose_error_statistics_top
    import pes_pkg::*;
#(
    parameter int COUNT_BITS  = PES_COUNT_BITS,
    parameter int NUM_TARGETS = PES_NUM_TARGETS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: gate limit, unsigned Q10.16.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [25:0] i_cfg_data,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // pos_x[23:0], pos_y[47:24], pos_z[71:48]
    input  logic [2:0]  s_axis_tuser,   // req_type[1:0], target_id[2]
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // distance[25:0], mean_error[51:26],
                                        // std_error[77:52], zero[79:78]
    output logic [1:0]  m_axis_tuser    // accepted[0], stats_valid[1]
);

    localparam int TW     = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int DIST_W = 26;
    localparam int SSUM_W = 50;
    localparam int PROD_W = 2 * DIST_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ADD,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DSQ,
        ST_ACCUM,
        ST_DIVS_GO,
        ST_DIVS_WAIT,
        ST_DIVQ_GO,
        ST_DIVQ_WAIT,
        ST_VAR,
        ST_SD_GO,
        ST_SD_WAIT,
        ST_OUT
    } t_state;

    t_state r_state;

    logic [DIST_W-1:0]      r_gate;
    logic signed [23:0]     r_truth [3];
    logic signed [23:0]     r_pos [3];
    logic [1:0]             r_idx;
    logic [TW-1:0]          r_tgt;
    logic                   r_tgt_ok;
    logic [COUNT_BITS-1:0]  r_count [NUM_TARGETS];
    logic [SUM_W-1:0]       r_sum [NUM_TARGETS];
    logic [SQS_W-1:0]       r_sqs [NUM_TARGETS];

    logic [DIST_W-1:0]      r_sq_op;
    logic [PROD_W-1:0]      r_prod;
    logic [SSUM_W-1:0]      r_ssum;
    logic [SQS_W-1:0]       r_q;
    logic [SQS_W-1:0]       r_var;

    logic [DIST_W-1:0]      r_dist;
    logic                   r_acc;
    logic [DIST_W-1:0]      r_mean;
    logic [DIST_W-1:0]      r_sd;
    logic                   r_valid;

    logic                   r_m_valid;
    logic [79:0]            r_m_data;
    logic [1:0]             r_m_user;

    // Input field views.
    logic [1:0]         in_req;
    logic               in_tgt;
    logic signed [23:0] in_x;
    logic signed [23:0] in_y;
    logic signed [23:0] in_z;
    logic               in_tgt_ok;

    assign in_req    = s_axis_tuser[1:0];
    assign in_tgt    = s_axis_tuser[2];
    assign in_x      = s_axis_tdata[23:0];
    assign in_y      = s_axis_tdata[47:24];
    assign in_z      = s_axis_tdata[71:48];
    assign in_tgt_ok = (32'(in_tgt) < NUM_TARGETS);

    // Negation of a truth coordinate, saturating the most negative value.
    function automatic logic [23:0] neg_sat(input logic [23:0] v);
        logic [23:0] res;
        if (v == {1'b1, 23'd0}) begin
            res = {1'b0, {23{1'b1}}};
        end else begin
            res = -v;
        end
        return res;
    endfunction

    // Absolute coordinate difference of the current axis.
    logic signed [24:0] d_ax;
    logic [23:0]        abs_d;
    always_comb begin
        d_ax  = {r_pos[r_idx][23], r_pos[r_idx]} - {r_truth[r_idx][23], r_truth[r_idx]};
        abs_d = d_ax[24] ? 24'(-d_ax) : d_ax[23:0];
    end

    // Saturating accumulations for an accepted distance.
    logic [SUM_W:0] sum_inc;
    logic [SQS_W:0] sqs_inc;
    assign sum_inc = {1'b0, r_sum[r_tgt]} + (SUM_W + 1)'(r_dist);
    assign sqs_inc = {1'b0, r_sqs[r_tgt]} + (SQS_W + 1)'(r_prod);

    // Control of the shared divide / square-root unit.
    t_iter_ctrl            it_ctrl;
    logic [OPND_W-1:0]     it_operand;
    logic                  it_done;
    logic [OPND_W-1:0]     it_quot;
    logic [ROOT_W-1:0]     it_root;

    always_comb begin
        it_ctrl.start = 1'b0;
        it_ctrl.op    = OP_DIV;
        it_ctrl.steps = '0;
        it_operand    = '0;
        case (r_state)
            ST_ROOT_GO: begin
                it_ctrl.start = 1'b1;
                it_ctrl.op    = OP_SQRT;
                it_ctrl.steps = SQRT_STEPS;
                it_operand    = OPND_W'(r_ssum);
            end
            ST_DIVS_GO: begin
                it_ctrl.start = 1'b1;
                it_ctrl.steps = SUM_DIV_STEPS;
                it_operand    = {r_sum[r_tgt], (OPND_W - SUM_W)'(0)};
            end
            ST_DIVQ_GO: begin
                it_ctrl.start = 1'b1;
                it_ctrl.steps = SQS_DIV_STEPS;
                it_operand    = {r_sqs[r_tgt], (OPND_W - SQS_W)'(0)};
            end
            ST_SD_GO: begin
                it_ctrl.start = 1'b1;
                it_ctrl.op    = OP_SQRT;
                it_ctrl.steps = SQRT_STEPS;
                it_operand    = OPND_W'(r_var);
            end
            default: begin
                it_ctrl.start = 1'b0;
            end
        endcase
    end

    pes_iter_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (it_ctrl),
        .i_operand(it_operand),
        .i_divisor(r_count[r_tgt]),
        .o_done   (it_done),
        .o_quot   (it_quot),
        .o_root   (it_root)
    );

    // Squaring multiplier, registered every cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= r_sq_op * r_sq_op;
    end

    // Sequencer, statistics state and output register.
    always_ff @(posedge i_clk) begin
        if (i_cfg_valid) begin
            r_gate <= i_cfg_data;
        end
        if (r_m_valid && m_axis_tready) begin
            r_m_valid <= 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    r_pos[0] <= in_x;
                    r_pos[1] <= in_y;
                    r_pos[2] <= in_z;
                    r_tgt    <= TW'(in_tgt);
                    r_tgt_ok <= in_tgt_ok;
                    r_idx    <= 2'd0;
                    r_ssum   <= '0;
                    r_dist   <= '0;
                    r_acc    <= 1'b0;
                    r_mean   <= '0;
                    r_sd     <= '0;
                    r_valid  <= 1'b0;
                    case (in_req)
                        REQ_TRUTH: begin
                            r_truth[0] <= in_x;
                            r_truth[1] <= neg_sat(in_y);
                            r_truth[2] <= neg_sat(in_z);
                            r_state    <= ST_OUT;
                        end
                        REQ_ESTIMATE: begin
                            r_state <= ST_DIFF;
                        end
                        REQ_REPORT: begin
                            if (in_tgt_ok && r_count[TW'(in_tgt)] != '0) begin
                                r_state <= ST_DIVS_GO;
                            end else begin
                                r_state <= ST_OUT;
                            end
                        end
                        default: begin
                            r_state <= ST_OUT;
                        end
                    endcase
                end
            end
            // Sum of squared axis differences, one axis per pass.
            ST_DIFF: begin
                r_sq_op <= DIST_W'(abs_d);
                r_state <= ST_MUL;
            end
            ST_MUL: begin
                r_state <= ST_ADD;
            end
            ST_ADD: begin
                r_ssum <= r_ssum + SSUM_W'(r_prod);
                if (r_idx == 2'd2) begin
                    r_state <= ST_ROOT_GO;
                end else begin
                    r_idx   <= r_idx + 2'd1;
                    r_state <= ST_DIFF;
                end
            end
            ST_ROOT_GO: begin
                r_state <= ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (it_done) begin
                    r_dist  <= it_root[DIST_W-1:0];
                    r_sq_op <= it_root[DIST_W-1:0];
                    r_state <= ST_DSQ;
                end
            end
            ST_DSQ: begin
                r_state <= ST_ACCUM;
            end
            // Gate and accumulate the distance into the chosen target.
            ST_ACCUM: begin
                if (r_tgt_ok && r_dist <= r_gate && r_count[r_tgt] != '1) begin
                    r_count[r_tgt] <= r_count[r_tgt] + COUNT_BITS'(1);
                    r_sum[r_tgt]   <= sum_inc[SUM_W] ? '1 : sum_inc[SUM_W-1:0];
                    r_sqs[r_tgt]   <= sqs_inc[SQS_W] ? '1 : sqs_inc[SQS_W-1:0];
                    r_acc          <= 1'b1;
                end
                r_state <= ST_OUT;
            end
            // Report: mean, mean of squares, variance, then its root.
            ST_DIVS_GO: begin
                r_state <= ST_DIVS_WAIT;
            end
            ST_DIVS_WAIT: begin
                if (it_done) begin
                    r_mean  <= it_quot[DIST_W-1:0];
                    r_sq_op <= it_quot[DIST_W-1:0];
                    r_state <= ST_DIVQ_GO;
                end
            end
            ST_DIVQ_GO: begin
                r_state <= ST_DIVQ_WAIT;
            end
            ST_DIVQ_WAIT: begin
                if (it_done) begin
                    r_q     <= it_quot[SQS_W-1:0];
                    r_state <= ST_VAR;
                end
            end
            ST_VAR: begin
                r_var   <= (r_q > SQS_W'(r_prod)) ? r_q - SQS_W'(r_prod) : '0;
                r_state <= ST_SD_GO;
            end
            ST_SD_GO: begin
                r_state <= ST_SD_WAIT;
            end
            ST_SD_WAIT: begin
                if (it_done) begin
                    r_sd    <= it_root[DIST_W-1:0];
                    r_valid <= 1'b1;
                    r_state <= ST_OUT;
                end
            end
            // Hand the result to the output register once it is free.
            ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    r_m_data  <= {2'b00, r_sd, r_mean, r_dist};
                    r_m_user  <= {r_valid, r_acc};
                    r_m_valid <= 1'b1;
                    r_state   <= ST_IDLE;
                end
            end
            default: begin
                r_state <= ST_IDLE;
            end
        endcase

        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_gate    <= DIST_W'(131072);
            for (int i = 0; i < 3; i++) begin
                r_truth[i] <= '0;
            end
            for (int t = 0; t < NUM_TARGETS; t++) begin
                r_count[t] <= '0;
                r_sum[t]   <= '0;
                r_sqs[t]   <= '0;
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// File: verif/tb_pose_error_statistics_top.sv
// Testbench for pose_error_statistics_top: drives truth, estimate, report and unused requests
// and checks every result item against an in-bench scoring model of the block.
// Depends on pes_pkg and the RTL of pose_error_statistics_top.
module tb_pose_error_statistics_top;
    import pes_pkg::*;

    // The package names three request kinds; code 3 is unused but still legal on the bus.
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam logic [25:0] GATE_RESET  = 26'd131072;
    localparam logic [25:0] GATE_MAX    = 26'h3FFFFFF;
    localparam logic [23:0] COORD_MIN   = 24'h800000;
    localparam logic [23:0] COORD_MAX   = 24'h7FFFFF;
    localparam logic [63:0] SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] SQ_LIMIT    = (64'd1 << SQS_W) - 64'd1;

    // One result item as the block reports it.
    typedef struct packed {
        logic [25:0] distance;
        logic        accepted;
        logic [25:0] mean;
        logic [25:0] spread;
        logic        valid;
    } t_score;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [25:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;    // pos_x[23:0], pos_y[47:24], pos_z[71:48]
    logic [2:0]  s_axis_tuser = '0;    // req_type[1:0], target_id[2]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;         // distance[25:0], mean_error[51:26], std_error[77:52]
    logic [1:0]  m_axis_tuser;         // accepted[0], stats_valid[1]

    // Scoring model state, kept in step with the block at each accepted item.
    logic [25:0]               gate_limit_q = GATE_RESET;
    logic signed [23:0]        truth_x_q = '0;
    logic signed [23:0]        truth_y_q = '0;
    logic signed [23:0]        truth_z_q = '0;
    logic [PES_COUNT_BITS-1:0] hits [PES_NUM_TARGETS] = '{default: '0};
    logic [63:0]               err_sum [PES_NUM_TARGETS] = '{default: '0};
    logic [63:0]               err_sq_sum [PES_NUM_TARGETS] = '{default: '0};

    t_score expected_scores [$];
    int     mismatches = 0;
    bit     bursty = 1'b1;
    int     stall_left = 0;

    pose_error_statistics_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake.
    initial begin
        #24000000;
        $display("tb_pose_error_statistics_top: errors");
        $finish;
    end

    // Floor square root, one result bit per pass.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bit_w;
        logic [63:0] rest;
        root = '0;
        rest = v;
        bit_w = 64'd1 << 62;
        while (bit_w > rest) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (rest >= root + bit_w) begin
                rest = rest - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // Negation that keeps the most negative value inside the 24-bit range.
    function automatic logic signed [23:0] neg_clamped(input logic signed [23:0] v);
        return (v == 24'sh800000) ? 24'sh7FFFFF : -v;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, b, lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    // Applies one request to the model state and returns the result item it causes.
    task automatic score_request(input logic [1:0] req, input logic tgt,
                                 input logic [23:0] x, y, z, output t_score res);
        longint      dx, dy, dz;
        logic [63:0] n, m, q, m2, variance;
        res = '0;
        case (req)
            REQ_TRUTH: begin
                truth_x_q = x;
                truth_y_q = neg_clamped(y);
                truth_z_q = neg_clamped(z);
            end
            REQ_ESTIMATE: begin
                dx = longint'($signed(x)) - longint'(truth_x_q);
                dy = longint'($signed(y)) - longint'(truth_y_q);
                dz = longint'($signed(z)) - longint'(truth_z_q);
                res.distance = 26'(int_sqrt(64'(dx * dx + dy * dy + dz * dz)));
                if (int'(tgt) < PES_NUM_TARGETS && res.distance <= gate_limit_q
                        && hits[tgt] != '1) begin
                    hits[tgt] = hits[tgt] + 1'b1;
                    err_sum[tgt] = sat_add(err_sum[tgt], 64'(res.distance), SUM_LIMIT);
                    err_sq_sum[tgt] = sat_add(err_sq_sum[tgt],
                                              64'(res.distance) * 64'(res.distance), SQ_LIMIT);
                    res.accepted = 1'b1;
                end
            end
            REQ_REPORT: begin
                if (int'(tgt) < PES_NUM_TARGETS && hits[tgt] != 0) begin
                    n = 64'(hits[tgt]);
                    m = err_sum[tgt] / n;
                    q = err_sq_sum[tgt] / n;
                    m2 = m * m;
                    variance = (q > m2) ? q - m2 : 64'd0;
                    res.mean = 26'(m);
                    res.spread = 26'(int_sqrt(variance));
                    res.valid = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Offers one request item, waits for it to be taken and records its expected result.
    task automatic send_item(input logic [1:0] req, input logic tgt,
                             input logic [23:0] x, y, z);
        t_score due;
        if (bursty && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= {tgt, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        score_request(req, tgt, x, y, z, due);
        expected_scores = {expected_scores, due};
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gate(input logic [25:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        gate_limit_q = value;
    endtask

    function automatic logic [23:0] any_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [23:0] near_coord(input logic [23:0] center, input int radius);
        int off;
        off = int'($urandom_range(0, 2 * radius)) - radius;
        return center + 24'(off);
    endfunction

    // Mostly estimates scattered around the stored truth, so that the gate decides often.
    task automatic send_random_request();
        int          pick;
        int          radius;
        logic        tgt;
        pick = $urandom_range(0, 99);
        tgt = 1'($urandom_range(0, 1));
        if (pick < 6) begin
            send_item(REQ_TRUTH, tgt, any_coord(), any_coord(), any_coord());
        end else if (pick < 16) begin
            send_item(REQ_REPORT, tgt, any_coord(), any_coord(), any_coord());
        end else if (pick < 18) begin
            send_item(REQ_UNUSED, tgt, any_coord(), any_coord(), any_coord());
        end else if (pick < 26) begin
            send_item(REQ_ESTIMATE, tgt, any_coord(), any_coord(), any_coord());
        end else begin
            case ($urandom_range(0, 6))
                0:       radius = 0;
                1:       radius = 64;
                2:       radius = 4096;
                3:       radius = 65536;
                4:       radius = 131072;
                5:       radius = 1 << 20;
                default: radius = (gate_limit_q > 26'(1 << 22)) ? (1 << 22)
                                                                 : int'(gate_limit_q);
            endcase
            send_item(REQ_ESTIMATE, tgt, near_coord(truth_x_q, radius),
                      near_coord(truth_y_q, radius), near_coord(truth_z_q, radius));
        end
    endtask

    // Reports on targets that have no samples yet, and the unused request kind.
    task automatic test_empty_reports();
        send_item(REQ_REPORT, 1'b0, '0, '0, '0);
        send_item(REQ_REPORT, 1'b1, COORD_MAX, COORD_MIN, COORD_MAX);
        send_item(REQ_UNUSED, 1'b1, '1, '1, '1);
    endtask

    // Truth points at the coordinate extremes, including the clamped negation of the minimum.
    task automatic test_truth_negation();
        send_item(REQ_TRUTH, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(REQ_ESTIMATE, 1'b0, COORD_MIN, COORD_MAX, COORD_MAX);
        send_item(REQ_ESTIMATE, 1'b1, COORD_MAX, COORD_MIN, COORD_MIN);
        send_item(REQ_TRUTH, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(REQ_ESTIMATE, 1'b1, COORD_MAX, 24'h800001, 24'h800001);
        send_item(REQ_TRUTH, 1'b0, '0, '0, '0);
        send_item(REQ_ESTIMATE, 1'b0, 24'd65536, '0, '0);
        // Exactly on the reset gate, then one step past it.
        send_item(REQ_ESTIMATE, 1'b1, 24'd131072, '0, '0);
        send_item(REQ_ESTIMATE, 1'b1, 24'd131073, '0, '0);
        send_item(REQ_REPORT, 1'b0, '0, '0, '0);
        send_item(REQ_REPORT, 1'b1, '0, '0, '0);
    endtask

    // A zero gate accepts only an exact hit.
    task automatic test_gate_extremes();
        write_gate('0);
        send_item(REQ_ESTIMATE, 1'b0, '0, '0, '0);
        send_item(REQ_ESTIMATE, 1'b0, 24'd1, '0, '0);
        send_item(REQ_ESTIMATE, 1'b1, '0, '0, '1);
        send_item(REQ_REPORT, 1'b0, '0, '0, '0);
    endtask

    // Repeated largest distances under the widest gate push the square sum to its limit.
    task automatic test_square_sum_saturation();
        write_gate(GATE_MAX);
        send_item(REQ_TRUTH, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
        for (int i = 0; i < 64; i++) begin
            if (i % 8 == 7) begin
                send_item(REQ_REPORT, 1'b1, '0, '0, '0);
            end else begin
                send_item(REQ_ESTIMATE, 1'b1, COORD_MAX - 24'(i), COORD_MIN, COORD_MIN);
            end
        end
        send_item(REQ_REPORT, 1'b0, '0, '0, '0);
    endtask

    // Random traffic under a series of gate settings, extremes among them.
    task automatic test_random_traffic();
        logic [25:0] gate_plan [6];
        gate_plan = '{GATE_RESET, '0, GATE_MAX, 26'($urandom_range(0, 67108863)),
                      26'($urandom_range(0, 262144)), 26'd1};
        foreach (gate_plan[p]) begin
            write_gate(gate_plan[p]);
            repeat (230) send_random_request();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_unstalled_tail();
        write_gate(26'($urandom_range(0, 262144)));
        bursty = 1'b0;
        repeat (150) send_random_request();
    endtask

    task automatic compare_field(input string name, input logic [63:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stall bursts on tready while bursty is set.
    always @(posedge i_clk) begin
        if (bursty && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(1, 15);
            m_axis_tready <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // Each result item taken is compared with the oldest expected one.
    always @(posedge i_clk) begin : result_check
        t_score want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_scores.size() == 0) begin
                $display("%0t: unexpected result item, expected none actual data %h user %h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_scores.pop_front();
                compare_field("distance", 64'(want.distance), 64'(m_axis_tdata[25:0]));
                compare_field("accepted", 64'(want.accepted), 64'(m_axis_tuser[0]));
                compare_field("mean_error", 64'(want.mean), 64'(m_axis_tdata[51:26]));
                compare_field("std_error", 64'(want.spread), 64'(m_axis_tdata[77:52]));
                compare_field("stats_valid", 64'(want.valid), 64'(m_axis_tuser[1]));
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_reports();
        test_truth_negation();
        test_gate_extremes();
        test_square_sum_saturation();
        test_random_traffic();
        test_unstalled_tail();
        wait_idle();
        // Let any stray result item surface before judging the run.
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_pose_error_statistics_top: clean");
        end else begin
            $display("tb_pose_error_statistics_top: errors");
        end
        $finish;
    end

endmodule

// File: pose_error_statistics_top.f
rtl/pes_pkg.sv
rtl/pes_iter_unit.sv
rtl/pose_error_statistics_top.sv
verif/tb_pose_error_statistics_top.sv
